// ----- hw/rtl/lcsdd_pkg.sv -----
// Shared types and constants for the LCS deletion-distance block.
package lcsdd_pkg;

   localparam int MAX_LEN_DEFAULT = 64;

   localparam logic [1:0] CMD_FIRST  = 2'd0;
   localparam logic [1:0] CMD_SECOND = 2'd1;
   localparam logic [1:0] CMD_RUN    = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [6:0] lcs_length;
      logic [7:0] deletion_distance;
      logic       overflowed;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic run;
      logic read;
      logic calc;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic empty;
      logic last_col;
      logic last_row;
   } ctrl_status_type;

endpackage

// ----- hw/rtl/lcsdd_ctrl.sv -----
// Sequencer for string loads and the row-by-row LCS table walk.
module lcsdd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                cmd,
   input  lcsdd_pkg::ctrl_status_type status,
   output logic                      busy,
   output lcsdd_pkg::ctrl_cmd_type    ctl
);

   lcsdd_pkg::state_type state_ff;
   lcsdd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcsdd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      busy       = 1'b1;
      case (state_ff)
         lcsdd_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (cmd == lcsdd_pkg::CMD_FIRST || cmd == lcsdd_pkg::CMD_SECOND) begin
                  ctl.load = 1'b1;
               end else if (cmd == lcsdd_pkg::CMD_RUN) begin
                  ctl.run = 1'b1;
                  if (status.empty) begin
                     state_in = lcsdd_pkg::ST_FINISH;
                  end else begin
                     state_in = lcsdd_pkg::ST_READ;
                  end
               end
            end
         end
         lcsdd_pkg::ST_READ: begin
            ctl.read = 1'b1;
            state_in = lcsdd_pkg::ST_CALC;
         end
         lcsdd_pkg::ST_CALC: begin
            ctl.calc = 1'b1;
            if (status.last_col && status.last_row) begin
               state_in = lcsdd_pkg::ST_FINISH;
            end else begin
               state_in = lcsdd_pkg::ST_READ;
            end
         end
         lcsdd_pkg::ST_FINISH: begin
            ctl.finish = 1'b1;
            state_in   = lcsdd_pkg::ST_IDLE;
         end
         default: begin
            state_in = lcsdd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/lcsdd_datapath.sv -----
// Symbol stores, score row memory, cell update and result register.
module lcsdd_datapath #(
   parameter int MAX_LEN = lcsdd_pkg::MAX_LEN_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lcsdd_pkg::req_type          req_item,
   input  lcsdd_pkg::ctrl_cmd_type     ctl,
   output lcsdd_pkg::ctrl_status_type  status,
   output logic                       rsp_valid,
   output lcsdd_pkg::rsp_type          rsp_item
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [7:0]       first_mem  [MAX_LEN];
   logic [7:0]       second_mem [MAX_LEN];
   logic [CNT_W-1:0] score_mem  [MAX_LEN];

   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] m_ff, m_in;
   logic             drop_ff, drop_in;
   logic [CNT_W-1:0] ci_ff, ci_in;
   logic [CNT_W-1:0] cj_ff, cj_in;
   logic             rsp_valid_ff;

   logic [7:0]       a_rd_ff;
   logic [7:0]       b_rd_ff;
   logic [CNT_W-1:0] above_rd_ff;
   logic             row0_ff;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] diag_ff, diag_in;
   logic [CNT_W-1:0] lcs_ff, lcs_in;
   lcsdd_pkg::rsp_type rsp_ff;

   logic [CNT_W-1:0] above;
   logic [CNT_W-1:0] score_new;
   logic             n_full;
   logic             m_full;
   logic [31:0]      dist_wide;
   logic [31:0]      lcs_wide;

   assign n_full = (n_ff == CNT_W'(MAX_LEN));
   assign m_full = (m_ff == CNT_W'(MAX_LEN));

   assign status.empty    = (n_ff == '0) || (m_ff == '0);
   assign status.last_col = ((cj_ff + 1'b1) == m_ff);
   assign status.last_row = ((ci_ff + 1'b1) == n_ff);

   // cell update: match takes diagonal + 1, else max of above and left
   assign above = row0_ff ? '0 : above_rd_ff;
   always_comb begin
      if (a_rd_ff == b_rd_ff) begin
         score_new = diag_ff + 1'b1;
      end else if (above > left_ff) begin
         score_new = above;
      end else begin
         score_new = left_ff;
      end
   end

   always_comb begin
      n_in    = n_ff;
      m_in    = m_ff;
      drop_in = drop_ff;
      ci_in   = ci_ff;
      cj_in   = cj_ff;
      left_in = left_ff;
      diag_in = diag_ff;
      lcs_in  = lcs_ff;
      if (ctl.load) begin
         if (req_item.cmd == lcsdd_pkg::CMD_FIRST) begin
            if (n_full) begin
               drop_in = 1'b1;
            end else begin
               n_in = n_ff + 1'b1;
            end
         end else begin
            if (m_full) begin
               drop_in = 1'b1;
            end else begin
               m_in = m_ff + 1'b1;
            end
         end
      end
      if (ctl.run) begin
         ci_in   = '0;
         cj_in   = '0;
         left_in = '0;
         diag_in = '0;
         lcs_in  = '0;
      end
      if (ctl.calc) begin
         lcs_in = score_new;
         if (status.last_col) begin
            ci_in   = ci_ff + 1'b1;
            cj_in   = '0;
            left_in = '0;
            diag_in = '0;
         end else begin
            cj_in   = cj_ff + 1'b1;
            left_in = score_new;
            diag_in = above;
         end
      end
      if (ctl.finish) begin
         n_in    = '0;
         m_in    = '0;
         drop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         m_ff         <= '0;
         drop_ff      <= 1'b0;
         ci_ff        <= '0;
         cj_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         m_ff         <= m_in;
         drop_ff      <= drop_in;
         ci_ff        <= ci_in;
         cj_ff        <= cj_in;
         rsp_valid_ff <= ctl.finish;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      diag_ff <= diag_in;
      lcs_ff  <= lcs_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.load && req_item.cmd == lcsdd_pkg::CMD_FIRST && !n_full) begin
         first_mem[n_ff[IDX_W-1:0]] <= req_item.symbol;
      end
      if (ctl.load && req_item.cmd == lcsdd_pkg::CMD_SECOND && !m_full) begin
         second_mem[m_ff[IDX_W-1:0]] <= req_item.symbol;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.read) begin
         a_rd_ff     <= first_mem[ci_ff[IDX_W-1:0]];
         b_rd_ff     <= second_mem[cj_ff[IDX_W-1:0]];
         above_rd_ff <= score_mem[cj_ff[IDX_W-1:0]];
         row0_ff     <= (ci_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.calc) begin
         score_mem[cj_ff[IDX_W-1:0]] <= score_new;
      end
   end

   assign lcs_wide  = 32'(lcs_ff);
   assign dist_wide = 32'(n_ff) + 32'(m_ff) - (lcs_wide << 1);

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_ff.lcs_length        <= lcs_wide[6:0];
         rsp_ff.deletion_distance <= dist_wide[7:0];
         rsp_ff.overflowed        <= drop_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- hw/rtl/lcs_deletion_distance.sv -----
// LCS length and deletion distance: append beats load one symbol per cycle while idle.
// A compute beat walks the table in READ and CALC, then FINISH registers the result;
// each table cell costs a read and a write of the score row memory.
// busy stays high from the compute beat until the result cycle; appends never raise it.
// rsp_valid lasts one cycle and cannot be stalled by the receiver.
// Synchronous reset empties both strings and clears the drop flag; stores keep contents.
module lcs_deletion_distance #(
   parameter int MAX_LEN = lcsdd_pkg::MAX_LEN_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  lcsdd_pkg::req_type  req_item,
   output logic               rsp_valid,
   output lcsdd_pkg::rsp_type  rsp_item
);

   lcsdd_pkg::ctrl_cmd_type    ctl;
   lcsdd_pkg::ctrl_status_type status;

   lcsdd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cmd    (req_item.cmd),
      .status (status),
      .busy   (busy),
      .ctl    (ctl)
   );

   lcsdd_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .ctl       (ctl),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- verif/lcsdd_checker.sv -----
// Checker for lcs_deletion_distance: tracks both strings, predicts each result and compares.
`timescale 1ns / 100ps

module lcsdd_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  lcsdd_pkg::req_type req_item,
   input  logic               rsp_valid,
   input  lcsdd_pkg::rsp_type rsp_item,
   output int                 error_count,
   output int                 pending_count
);

   localparam int DEPTH = lcsdd_pkg::MAX_LEN_DEFAULT;

   logic [7:0]         first_str  [DEPTH];
   logic [7:0]         second_str [DEPTH];
   int                 first_len;
   int                 second_len;
   logic               dropped;
   lcsdd_pkg::rsp_type expected_q [$];

   initial begin
      error_count = 0;
      pending_count = 0;
      first_len = 0;
      second_len = 0;
      dropped = 1'b0;
   end

   // full 2-D table, entry (i,j) holds the LCS of the first i and first j symbols
   function automatic lcsdd_pkg::rsp_type predict_scores();
      int                 tbl [DEPTH+1][DEPTH+1];
      int                 common;
      lcsdd_pkg::rsp_type r;
      for (int i = 0; i <= first_len; i++) begin
         for (int j = 0; j <= second_len; j++) begin
            if (i == 0 || j == 0) begin
               tbl[i][j] = 0;
            end else if (first_str[i-1] == second_str[j-1]) begin
               tbl[i][j] = tbl[i-1][j-1] + 1;
            end else begin
               tbl[i][j] = (tbl[i-1][j] > tbl[i][j-1]) ? tbl[i-1][j] : tbl[i][j-1];
            end
         end
      end
      common = tbl[first_len][second_len];
      r.lcs_length = 7'(common);
      r.deletion_distance = 8'(first_len + second_len - 2 * common);
      r.overflowed = dropped;
      return r;
   endfunction

   always @(posedge clock) begin
      lcsdd_pkg::rsp_type exp_rsp;
      if (reset) begin
         first_len = 0;
         second_len = 0;
         dropped = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $display("%0t: result beat with nothing expected: lcs=%0d dist=%0d ovf=%0b",
                        $time, rsp_item.lcs_length, rsp_item.deletion_distance,
                        rsp_item.overflowed);
               error_count++;
            end else begin
               exp_rsp = expected_q.pop_front();
               if (rsp_item.lcs_length !== exp_rsp.lcs_length)
                  $display("%0t: lcs_length expected %0d, got %0d", $time,
                           exp_rsp.lcs_length, rsp_item.lcs_length);
               if (rsp_item.deletion_distance !== exp_rsp.deletion_distance)
                  $display("%0t: deletion_distance expected %0d, got %0d", $time,
                           exp_rsp.deletion_distance, rsp_item.deletion_distance);
               if (rsp_item.overflowed !== exp_rsp.overflowed)
                  $display("%0t: overflowed expected %0b, got %0b", $time,
                           exp_rsp.overflowed, rsp_item.overflowed);
               if (rsp_item !== exp_rsp)
                  error_count++;
            end
         end
         if (start && !busy) begin
            case (req_item.cmd)
               lcsdd_pkg::CMD_FIRST: begin
                  if (first_len < DEPTH) begin
                     first_str[first_len] = req_item.symbol;
                     first_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               lcsdd_pkg::CMD_SECOND: begin
                  if (second_len < DEPTH) begin
                     second_str[second_len] = req_item.symbol;
                     second_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               lcsdd_pkg::CMD_RUN: begin
                  expected_q.push_back(predict_scores());
                  first_len = 0;
                  second_len = 0;
                  dropped = 1'b0;
               end
               default: ;
            endcase
         end
      end
      pending_count = expected_q.size();
   end

endmodule

// ----- verif/tb_lcs_deletion_distance.sv -----
// Testbench top for lcs_deletion_distance: clock, reset, stimulus phases and verdict.
`timescale 1ns / 100ps

module tb_lcs_deletion_distance;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int PHASE_BEATS = 400;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   lcsdd_pkg::req_type req_item = '0;
   logic               rsp_valid;
   lcsdd_pkg::rsp_type rsp_item;
   int                 error_count;
   int                 pending_count;
   int                 cycle_count = 0;
   int                 idle_pct = 0;
   int                 beat_count = 0;

   always #10 clock = ~clock;

   lcs_deletion_distance dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   lcsdd_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // start stays high across back-to-back beats; busy is sampled mid-cycle
   task automatic send_beat(input logic [1:0] cmd, input logic [7:0] symbol);
      logic taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= '{cmd: cmd, symbol: symbol};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
      if (cmd != CMD_UNUSED)
         beat_count++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_symbol(input logic [7:0] base, input int alpha);
      return base + 8'($urandom_range(alpha - 1));
   endfunction

   // both strings filled to capacity and up to two past it: identical (lcs 64) or disjoint (distance 128)
   task automatic fill_strings(input bit same);
      logic [7:0] pattern [64];
      int         extra_first;
      int         extra_second;
      extra_first = $urandom_range(2);
      extra_second = $urandom_range(2);
      for (int i = 0; i < 64; i++) begin
         pattern[i] = 8'($urandom_range(255));
         if (!same)
            pattern[i][7] = 1'b0;
      end
      for (int i = 0; i < 64 + extra_first; i++)
         send_beat(lcsdd_pkg::CMD_FIRST, pattern[i % 64]);
      for (int i = 0; i < 64 + extra_second; i++)
         send_beat(lcsdd_pkg::CMD_SECOND,
                   same ? pattern[i % 64] : {1'b1, pattern[i % 64][6:0]});
      send_beat(lcsdd_pkg::CMD_RUN, 8'($urandom_range(255)));
   endtask

   // interleaved loads, mostly short, often narrow alphabets for frequent matches
   task automatic play_sequence();
      int         size_pick;
      int         len_first;
      int         len_second;
      int         got_first;
      int         got_second;
      int         alpha;
      logic [7:0] base;
      size_pick = $urandom_range(99);
      if (size_pick < 70) begin
         len_first = $urandom_range(8);
         len_second = $urandom_range(8);
      end else if (size_pick < 96) begin
         len_first = $urandom_range(24);
         len_second = $urandom_range(24);
      end else begin
         len_first = $urandom_range(40, 64);
         len_second = $urandom_range(40, 64);
      end
      alpha = $urandom_range(1) ? $urandom_range(1, 4) : 256;
      base = 8'($urandom_range(255));
      got_first = 0;
      got_second = 0;
      while (got_first < len_first || got_second < len_second) begin
         if ($urandom_range(49) == 0)
            send_beat(CMD_UNUSED, 8'($urandom_range(255)));
         if (got_first < len_first && (got_second >= len_second || $urandom_range(1))) begin
            send_beat(lcsdd_pkg::CMD_FIRST, pick_symbol(base, alpha));
            got_first++;
         end else begin
            send_beat(lcsdd_pkg::CMD_SECOND, pick_symbol(base, alpha));
            got_second++;
         end
      end
      // occasionally skip the compute so strings carry into the next sequence
      if ($urandom_range(9) != 0)
         send_beat(lcsdd_pkg::CMD_RUN, 8'($urandom_range(255)));
   endtask

   task automatic run_phase(input int pct, input bit fill_same);
      idle_pct = pct;
      beat_count = 0;
      fill_strings(fill_same);
      while (beat_count < PHASE_BEATS)
         play_sequence();
      send_beat(lcsdd_pkg::CMD_RUN, 8'($urandom_range(255)));
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 0;
      send_beat(lcsdd_pkg::CMD_RUN, 8'h00);
      send_beat(lcsdd_pkg::CMD_FIRST, 8'h00);
      send_beat(lcsdd_pkg::CMD_FIRST, 8'hFF);
      send_beat(lcsdd_pkg::CMD_SECOND, 8'hFF);
      send_beat(lcsdd_pkg::CMD_SECOND, 8'h00);
      send_beat(lcsdd_pkg::CMD_SECOND, 8'h80);
      send_beat(lcsdd_pkg::CMD_RUN, 8'hFF);
      send_beat(lcsdd_pkg::CMD_FIRST, 8'h12);
      send_beat(lcsdd_pkg::CMD_FIRST, 8'h34);
      send_beat(CMD_UNUSED, 8'hA5);
      send_beat(lcsdd_pkg::CMD_RUN, 8'h00);
      send_beat(lcsdd_pkg::CMD_SECOND, 8'h01);
      send_beat(lcsdd_pkg::CMD_RUN, 8'h5A);
      send_beat(lcsdd_pkg::CMD_FIRST, 8'h5A);
      send_beat(lcsdd_pkg::CMD_SECOND, 8'h5A);
      send_beat(lcsdd_pkg::CMD_RUN, 8'hC3);
      wait_drained();

      run_phase(0, 1'b1);
      run_phase(80, 1'b0);
      run_phase(24, 1'b1);
      run_phase(0, 1'b0);

      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/lcsdd_pkg.sv
hw/rtl/lcsdd_ctrl.sv
hw/rtl/lcsdd_datapath.sv
hw/rtl/lcs_deletion_distance.sv
verif/lcsdd_checker.sv
verif/tb_lcs_deletion_distance.sv
